// ===== rtl/wsrd_pkg.sv =====
// Shared types and constants for the wheel slip rumble decider.
// No dependencies; every other file in rtl/ uses this package.
package wsrd_pkg;

  // Fixed-point layout
  localparam int FRAC_SHIFT = 14;
  localparam int CAR_W      = 16;
  localparam int RATE_W     = 16;
  localparam int RAD_W      = 16;
  localparam int MAG_W      = RATE_W + 1;
  localparam int WPROD_W    = MAG_W + RAD_W;
  localparam int WS_W       = 17;                // |rate| * radius >> 14 fits 17 bits
  localparam int THR_W      = 16;
  localparam int APROD_W    = THR_W + WS_W;      // threshold * wheel speed
  localparam int CPROD_W    = THR_W + CAR_W;     // threshold * car speed
  localparam int SUM_W      = WS_W + 2;
  localparam int PED_W      = 8;
  localparam int STAT_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_WHEELS = 4;

  // Status word bit positions
  localparam int ST_ACTIVE    = 0;
  localparam int ST_RPM_CAP   = 5;
  localparam int ST_STABILITY = 10;
  localparam int ST_TRACTION  = 11;

  // Register reset values
  localparam logic [THR_W-1:0] THR_RESET = 16'd13107;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_THR   = 3'd0,
    REG_DECEL_THR   = 3'd1,
    REG_ACCEL_FLOOR = 3'd2,
    REG_DECEL_FLOOR = 3'd3,
    REG_THR_FLOOR   = 3'd4,
    REG_BRK_FLOOR   = 3'd5,
    REG_ACCEL_SRC   = 3'd6,
    REG_DECEL_SRC   = 3'd7
  } reg_idx_t;

  // Rumble source selects
  typedef enum logic [1:0] {
    ASRC_ANY      = 2'd0,
    ASRC_MEAN     = 2'd1,
    ASRC_TRACTION = 2'd2,
    ASRC_REVLIM   = 2'd3
  } accel_src_t;

  typedef enum logic [1:0] {
    DSRC_ANY       = 2'd0,
    DSRC_MEAN      = 2'd1,
    DSRC_STABILITY = 2'd2,
    DSRC_NEVER     = 2'd3
  } decel_src_t;

  typedef struct packed {
    logic [THR_W-1:0] accel_slip_threshold;
    logic [THR_W-1:0] decel_slip_threshold;
    logic [CAR_W-1:0] accel_speed_floor;
    logic [CAR_W-1:0] decel_speed_floor;
    logic [PED_W-1:0] throttle_floor;
    logic [PED_W-1:0] brake_floor;
    accel_src_t       accel_source;
    decel_src_t       decel_source;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic rpm_cap;
    logic stability;
    logic traction;
  } flags_t;

  // Stage 1: wheel speeds
  typedef struct packed {
    logic [CAR_W-1:0]                 car;
    logic [NUM_WHEELS-1:0][WS_W-1:0]  ws;
    logic [PED_W-1:0]                 throttle;
    logic [PED_W-1:0]                 brake;
    flags_t                           flags;
  } s1_t;

  // Stage 2: threshold products and mean
  typedef struct packed {
    logic [CAR_W-1:0]                   car;
    logic [NUM_WHEELS-1:0][WS_W-1:0]    ws;
    logic [NUM_WHEELS-1:0][APROD_W-1:0] acc_prod;
    logic [CPROD_W-1:0]                 dec_car_prod;
    logic [WS_W-1:0]                    mean;
    logic [PED_W-1:0]                   throttle;
    logic [PED_W-1:0]                   brake;
    flags_t                             flags;
  } s2_t;

  // Stage 3: per-wheel verdicts and mean product
  typedef struct packed {
    logic [CAR_W-1:0]   car;
    logic               acc_any;
    logic               dec_any;
    logic [APROD_W-1:0] acc_mean_prod;
    logic [CPROD_W-1:0] dec_car_prod;
    logic [WS_W-1:0]    mean;
    logic [PED_W-1:0]   throttle;
    logic [PED_W-1:0]   brake;
    flags_t             flags;
  } s3_t;

endpackage

// ===== rtl/wsrd_wheel_speed.sv =====
// Stage 1: wheel ground speed from rotation rate and tire radius.
// Depends on wsrd_pkg.
module wsrd_wheel_speed (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  logic [wsrd_pkg::CAR_W-1:0]                  vehicle_speed,
  input  logic signed [wsrd_pkg::NUM_WHEELS-1:0][wsrd_pkg::RATE_W-1:0] rate,
  input  logic [wsrd_pkg::NUM_WHEELS-1:0][wsrd_pkg::RAD_W-1:0]         radius,
  input  logic [wsrd_pkg::PED_W-1:0]                  throttle_level,
  input  logic [wsrd_pkg::PED_W-1:0]                  brake_level,
  input  logic [wsrd_pkg::STAT_W-1:0]                 status_word,
  input  logic                                        rdy_down,
  output logic                                        rdy,
  output logic                                        v1_r,
  output wsrd_pkg::s1_t                               s1_r
);

  wsrd_pkg::s1_t s1_nxt;
  logic [wsrd_pkg::NUM_WHEELS-1:0][wsrd_pkg::MAG_W-1:0]   mag;
  logic [wsrd_pkg::NUM_WHEELS-1:0][wsrd_pkg::WPROD_W-1:0] prod;

  // stage loads when empty or when the next stage takes its word
  assign rdy = !v1_r || rdy_down;

  // |rate| without saturation, then scale by radius
  always_comb begin
    for (int i = 0; i < wsrd_pkg::NUM_WHEELS; i++) begin
      mag[i]  = rate[i][wsrd_pkg::RATE_W-1] ?
                (wsrd_pkg::MAG_W'(0) - {rate[i][wsrd_pkg::RATE_W-1], rate[i]}) :
                {1'b0, rate[i]};
      prod[i] = wsrd_pkg::WPROD_W'(mag[i]) * wsrd_pkg::WPROD_W'(radius[i]);
      s1_nxt.ws[i] = prod[i][wsrd_pkg::FRAC_SHIFT +: wsrd_pkg::WS_W];
    end
    s1_nxt.car             = vehicle_speed;
    s1_nxt.throttle        = throttle_level;
    s1_nxt.brake           = brake_level;
    s1_nxt.flags.active    = status_word[wsrd_pkg::ST_ACTIVE];
    s1_nxt.flags.rpm_cap   = status_word[wsrd_pkg::ST_RPM_CAP];
    s1_nxt.flags.stability = status_word[wsrd_pkg::ST_STABILITY];
    s1_nxt.flags.traction  = status_word[wsrd_pkg::ST_TRACTION];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

// ===== rtl/wsrd_slip.sv =====
// Stages 2 and 3: threshold products, wheel mean, per-wheel slip compares.
// Depends on wsrd_pkg.
module wsrd_slip (
  input  logic          clk,
  input  logic          rst_n,
  input  wsrd_pkg::cfg_t cfg,
  input  logic          v1,
  input  wsrd_pkg::s1_t s1,
  input  logic          rdy_down,
  output logic          rdy,
  output logic          v3_r,
  output wsrd_pkg::s3_t s3_r
);

  logic          v2_r;
  logic          rdy3;
  wsrd_pkg::s2_t s2_r, s2_nxt;
  wsrd_pkg::s3_t s3_nxt;
  logic [wsrd_pkg::SUM_W-1:0] sum;
  logic [wsrd_pkg::NUM_WHEELS-1:0] acc_hit, dec_hit;

  assign rdy3 = !v3_r || rdy_down;
  assign rdy  = !v2_r || rdy3;

  // stage 2: accel threshold times each wheel, decel threshold times car, mean
  always_comb begin
    sum = '0;
    for (int i = 0; i < wsrd_pkg::NUM_WHEELS; i++) begin
      s2_nxt.acc_prod[i] = wsrd_pkg::APROD_W'(cfg.accel_slip_threshold) *
                           wsrd_pkg::APROD_W'(s1.ws[i]);
      sum = sum + wsrd_pkg::SUM_W'(s1.ws[i]);
    end
    s2_nxt.dec_car_prod = wsrd_pkg::CPROD_W'(cfg.decel_slip_threshold) *
                          wsrd_pkg::CPROD_W'(s1.car);
    s2_nxt.mean     = sum[wsrd_pkg::SUM_W-1:2];
    s2_nxt.car      = s1.car;
    s2_nxt.ws       = s1.ws;
    s2_nxt.throttle = s1.throttle;
    s2_nxt.brake    = s1.brake;
    s2_nxt.flags    = s1.flags;
  end

  // stage 3: per-wheel compares, accel threshold times mean
  always_comb begin
    for (int i = 0; i < wsrd_pkg::NUM_WHEELS; i++) begin
      acc_hit[i] = wsrd_pkg::APROD_W'({s2_r.car, wsrd_pkg::FRAC_SHIFT'(0)}) <
                   s2_r.acc_prod[i];
      dec_hit[i] = wsrd_pkg::CPROD_W'({s2_r.ws[i], wsrd_pkg::FRAC_SHIFT'(0)}) <
                   s2_r.dec_car_prod;
    end
    s3_nxt.acc_any       = |acc_hit;
    s3_nxt.dec_any       = |dec_hit;
    s3_nxt.acc_mean_prod = wsrd_pkg::APROD_W'(cfg.accel_slip_threshold) *
                           wsrd_pkg::APROD_W'(s2_r.mean);
    s3_nxt.dec_car_prod  = s2_r.dec_car_prod;
    s3_nxt.mean          = s2_r.mean;
    s3_nxt.car           = s2_r.car;
    s3_nxt.throttle      = s2_r.throttle;
    s3_nxt.brake         = s2_r.brake;
    s3_nxt.flags         = s2_r.flags;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy)  v2_r <= v1;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && v1) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

// ===== rtl/wsrd_decide.sv =====
// Stage 4: mean slip compares, rumble gating and source select, output register.
// Depends on wsrd_pkg.
module wsrd_decide (
  input  logic          clk,
  input  logic          rst_n,
  input  wsrd_pkg::cfg_t cfg,
  input  logic          v3,
  input  wsrd_pkg::s3_t s3,
  input  logic          out_stall,
  output logic          rdy,
  output logic          out_valid,
  output logic          out_throttle_rumble,
  output logic          out_brake_rumble,
  output logic          out_accel_slip_any,
  output logic          out_decel_slip_any,
  output logic          out_accel_slip_mean,
  output logic          out_decel_slip_mean
);

  logic out_valid_r;
  logic thr_r, brk_r, acc_any_r, dec_any_r, acc_mean_r, dec_mean_r;
  logic thr_nxt, brk_nxt, acc_mean_nxt, dec_mean_nxt;
  logic thr_gate, brk_gate;

  assign rdy = !out_valid_r || !out_stall;

  // mean slip tests
  assign acc_mean_nxt = wsrd_pkg::APROD_W'({s3.car, wsrd_pkg::FRAC_SHIFT'(0)}) <
                        s3.acc_mean_prod;
  assign dec_mean_nxt = wsrd_pkg::CPROD_W'({s3.mean, wsrd_pkg::FRAC_SHIFT'(0)}) <
                        s3.dec_car_prod;

  // rumble enables: car active, speed and pedal at or above their floors
  assign thr_gate = s3.flags.active && (s3.car >= cfg.accel_speed_floor) &&
                    (s3.throttle >= cfg.throttle_floor);
  assign brk_gate = s3.flags.active && (s3.car >= cfg.decel_speed_floor) &&
                    (s3.brake >= cfg.brake_floor);

  always_comb begin
    unique case (cfg.accel_source)
      wsrd_pkg::ASRC_ANY:      thr_nxt = s3.acc_any;
      wsrd_pkg::ASRC_MEAN:     thr_nxt = acc_mean_nxt;
      wsrd_pkg::ASRC_TRACTION: thr_nxt = s3.flags.traction;
      wsrd_pkg::ASRC_REVLIM:   thr_nxt = s3.flags.rpm_cap;
      default:                 thr_nxt = 1'b0;
    endcase
    thr_nxt = thr_nxt && thr_gate;
  end

  always_comb begin
    unique case (cfg.decel_source)
      wsrd_pkg::DSRC_ANY:       brk_nxt = s3.dec_any;
      wsrd_pkg::DSRC_MEAN:      brk_nxt = dec_mean_nxt;
      wsrd_pkg::DSRC_STABILITY: brk_nxt = s3.flags.stability;
      wsrd_pkg::DSRC_NEVER:     brk_nxt = 1'b0;
      default:                  brk_nxt = 1'b0;
    endcase
    brk_nxt = brk_nxt && brk_gate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy) begin
      out_valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && v3) begin
      thr_r      <= thr_nxt;
      brk_r      <= brk_nxt;
      acc_any_r  <= s3.acc_any;
      dec_any_r  <= s3.dec_any;
      acc_mean_r <= acc_mean_nxt;
      dec_mean_r <= dec_mean_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_throttle_rumble = thr_r;
  assign out_brake_rumble    = brk_r;
  assign out_accel_slip_any  = acc_any_r;
  assign out_decel_slip_any  = dec_any_r;
  assign out_accel_slip_mean = acc_mean_r;
  assign out_decel_slip_mean = dec_mean_r;

endmodule

// ===== rtl/wheel_slip_rumble_decider.sv =====
// Top level of the wheel slip rumble decider: configuration registers and pipeline.
// Depends on wsrd_pkg, wsrd_wheel_speed, wsrd_slip and wsrd_decide.
//
// One telemetry word in, one decision word out. The block takes a new word every
// cycle unless out_stall backs up the pipeline; its decision word reaches the outputs
// through four register stages: wheel speed multiply, threshold multiplies and wheel
// mean, per-wheel compares with the mean multiply, then mean compares and rumble
// selection into the output register. The two levels of threshold multiplication
// set the depth. Each stage holds its word under out_stall and empty stages fill in,
// so no word is lost or repeated. Write the configuration registers only while no
// word is in flight; register writes take effect on the next cycle.
module wheel_slip_rumble_decider (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wsrd_pkg::CAR_W-1:0]          in_vehicle_speed,
  input  logic signed [wsrd_pkg::RATE_W-1:0]  in_rate_front_left,
  input  logic signed [wsrd_pkg::RATE_W-1:0]  in_rate_front_right,
  input  logic signed [wsrd_pkg::RATE_W-1:0]  in_rate_rear_left,
  input  logic signed [wsrd_pkg::RATE_W-1:0]  in_rate_rear_right,
  input  logic [wsrd_pkg::RAD_W-1:0]          in_radius_front_left,
  input  logic [wsrd_pkg::RAD_W-1:0]          in_radius_front_right,
  input  logic [wsrd_pkg::RAD_W-1:0]          in_radius_rear_left,
  input  logic [wsrd_pkg::RAD_W-1:0]          in_radius_rear_right,
  input  logic [wsrd_pkg::PED_W-1:0]          in_throttle_level,
  input  logic [wsrd_pkg::PED_W-1:0]          in_brake_level,
  input  logic [wsrd_pkg::STAT_W-1:0]         in_status_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_throttle_rumble,
  output logic                                out_brake_rumble,
  output logic                                out_accel_slip_any,
  output logic                                out_decel_slip_any,
  output logic                                out_accel_slip_mean,
  output logic                                out_decel_slip_mean,
  input  logic                                cfg_we,
  input  logic [wsrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsrd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  wsrd_pkg::cfg_t cfg_r;
  logic           rdy1, rdy2, rdy4;
  logic           v1, v3;
  wsrd_pkg::s1_t  s1;
  wsrd_pkg::s3_t  s3;
  logic signed [wsrd_pkg::NUM_WHEELS-1:0][wsrd_pkg::RATE_W-1:0] rate;
  logic [wsrd_pkg::NUM_WHEELS-1:0][wsrd_pkg::RAD_W-1:0]         radius;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_slip_threshold <= wsrd_pkg::THR_RESET;
      cfg_r.decel_slip_threshold <= wsrd_pkg::THR_RESET;
      cfg_r.accel_speed_floor    <= '0;
      cfg_r.decel_speed_floor    <= '0;
      cfg_r.throttle_floor       <= '0;
      cfg_r.brake_floor          <= '0;
      cfg_r.accel_source         <= wsrd_pkg::ASRC_ANY;
      cfg_r.decel_source         <= wsrd_pkg::DSRC_ANY;
    end else if (cfg_we) begin
      unique case (wsrd_pkg::reg_idx_t'(cfg_index))
        wsrd_pkg::REG_ACCEL_THR:   cfg_r.accel_slip_threshold <= cfg_wdata;
        wsrd_pkg::REG_DECEL_THR:   cfg_r.decel_slip_threshold <= cfg_wdata;
        wsrd_pkg::REG_ACCEL_FLOOR: cfg_r.accel_speed_floor    <= cfg_wdata;
        wsrd_pkg::REG_DECEL_FLOOR: cfg_r.decel_speed_floor    <= cfg_wdata;
        wsrd_pkg::REG_THR_FLOOR:
          cfg_r.throttle_floor <= cfg_wdata[wsrd_pkg::PED_W-1:0];
        wsrd_pkg::REG_BRK_FLOOR:
          cfg_r.brake_floor <= cfg_wdata[wsrd_pkg::PED_W-1:0];
        wsrd_pkg::REG_ACCEL_SRC:
          cfg_r.accel_source <= wsrd_pkg::accel_src_t'(cfg_wdata[1:0]);
        wsrd_pkg::REG_DECEL_SRC:
          cfg_r.decel_source <= wsrd_pkg::decel_src_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // wheel order: front left, front right, rear left, rear right
  assign rate   = {in_rate_rear_right, in_rate_rear_left,
                   in_rate_front_right, in_rate_front_left};
  assign radius = {in_radius_rear_right, in_radius_rear_left,
                   in_radius_front_right, in_radius_front_left};

  assign in_stall = !rdy1;

  wsrd_wheel_speed u_wheel (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .vehicle_speed  (in_vehicle_speed),
    .rate           (rate),
    .radius         (radius),
    .throttle_level (in_throttle_level),
    .brake_level    (in_brake_level),
    .status_word    (in_status_word),
    .rdy_down       (rdy2),
    .rdy            (rdy1),
    .v1_r           (v1),
    .s1_r           (s1)
  );

  wsrd_slip u_slip (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .v1       (v1),
    .s1       (s1),
    .rdy_down (rdy4),
    .rdy      (rdy2),
    .v3_r     (v3),
    .s3_r     (s3)
  );

  wsrd_decide u_decide (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .v3                  (v3),
    .s3                  (s3),
    .out_stall           (out_stall),
    .rdy                 (rdy4),
    .out_valid           (out_valid),
    .out_throttle_rumble (out_throttle_rumble),
    .out_brake_rumble    (out_brake_rumble),
    .out_accel_slip_any  (out_accel_slip_any),
    .out_decel_slip_any  (out_decel_slip_any),
    .out_accel_slip_mean (out_accel_slip_mean),
    .out_decel_slip_mean (out_decel_slip_mean)
  );

endmodule
